// ===== design/pmqs_pkg.sv =====
// shared types and codes of the priority message queue scheduler
// no dependencies
package pmqs_pkg;

  localparam int PAY_W       = 29;  // {sig, task, handle}
  localparam int CNT_W       = 7;
  localparam int MAX_RESULTS = 64;

  localparam logic [1:0] FUNC_POST     = 2'd0;
  localparam logic [1:0] FUNC_DISPATCH = 2'd1;
  localparam logic [1:0] FUNC_REMOVE   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_BAD_TASK = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] REG_TASK_COUNT = 2'd0;
  localparam logic [1:0] REG_MAP_LOW    = 2'd1;
  localparam logic [1:0] REG_MAP_HIGH   = 2'd2;

  // write strobes into the slot memory
  typedef struct packed {
    logic pay_we;
    logic nxt_we;
  } pmqs_wr_t;

endpackage

// ===== design/pmqs_slot_mem.sv =====
// slot pool memory: payload and link of every slot, one read port
// depends on pmqs_pkg
module pmqs_slot_mem #(
  parameter int SLOTS = 64
) (
  input  logic                         clk,
  input  pmqs_pkg::pmqs_wr_t           wr,
  input  logic [$clog2(SLOTS)-1:0]     pay_addr,
  input  logic [pmqs_pkg::PAY_W-1:0]   pay_wdata,
  input  logic [$clog2(SLOTS)-1:0]     nxt_addr,
  input  logic [$clog2(SLOTS):0]       nxt_wdata,
  input  logic [$clog2(SLOTS)-1:0]     rd_addr,
  output logic [pmqs_pkg::PAY_W-1:0]   rd_pay,
  output logic [$clog2(SLOTS):0]       rd_nxt
);
  localparam int IW = $clog2(SLOTS);

  logic [pmqs_pkg::PAY_W-1:0] pay_mem [SLOTS];
  logic [IW:0]                nxt_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.pay_we) begin
      pay_mem[pay_addr] <= pay_wdata;
    end
    if (wr.nxt_we) begin
      nxt_mem[nxt_addr] <= nxt_wdata;
    end
    rd_pay <= pay_mem[rd_addr];
    rd_nxt <= nxt_mem[rd_addr];
  end

endmodule

// ===== design/priority_message_queue_scheduler.sv =====
// Priority message queue scheduler: one linked FIFO per priority level in a shared slot pool.
// Post links the new slot behind the old tail when the level is already nonempty; dispatch
// reads the head slot; remove visits the list entries in turn and then delivers each result
// from a buffer, or a single empty result; each result is held until taken. The slot memory
// has a single read port. A new transaction is taken only once the last result of the
// previous one has been taken.
// Depends on pmqs_pkg and pmqs_slot_mem.
module priority_message_queue_scheduler #(
  parameter int LEVELS     = 8,
  parameter int MAX_TASKS  = 32,
  parameter int POOL_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // task_id, sig, msg_handle, threshold
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_handle, out_task, out_sig, out_level, removed_count,
                                  // ready_mask
  output logic [1:0]  out_tuser,  // status
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  localparam int IW = $clog2(POOL_SLOTS);
  localparam int LW = $clog2(LEVELS);
  localparam logic [IW:0] NIL = {1'b1, {IW{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_POST_LINK, S_DISP_DATA, S_REM_STEP, S_REM_DATA, S_BUF_RD, S_BUF_DATA, S_OUT
  } state_t;

  state_t state_r;

  logic [5:0]  task_count_r;
  logic [63:0] map_lo_r, map_hi_r;
  logic [LEVELS-1:0]     ready_r;
  logic [IW-1:0]         head_r [LEVELS];
  logic [IW-1:0]         tail_r [LEVELS];
  logic [POOL_SLOTS-1:0] free_r;

  logic [4:0]  tid_r;
  logic [7:0]  sig_r;
  logic [LW-1:0] li_r;
  logic [IW:0]   cur_r, prev_r;
  logic [IW:0]   steps_r;
  logic [IW-1:0] link_tail_r, link_slot_r;
  logic [pmqs_pkg::CNT_W-1:0] cnt_r, k_r;

  logic [pmqs_pkg::PAY_W-1:0] buf_mem [POOL_SLOTS];
  logic [pmqs_pkg::PAY_W-1:0] buf_rd_r;

  logic [1:0]  o_status_r;
  logic [pmqs_pkg::PAY_W-1:0] o_pay_r;
  logic [3:0]  o_level_r;
  logic [pmqs_pkg::CNT_W-1:0] o_cnt_r;
  logic        o_last_r;

  // input decode
  logic [4:0]  i_tid;
  logic [7:0]  i_sig;
  logic [15:0] i_hdl;
  logic [3:0]  i_thr;
  logic [3:0]  nib;
  logic        lvl_ok;
  logic [LW-1:0] i_li;
  logic          fs_found;
  logic [IW-1:0] fs;
  logic          any_ready;
  logic [LW-1:0] top_li;
  logic [4:0]    top_lvl;
  logic          in_acc;

  assign i_tid  = in_tdata[4:0];
  assign i_sig  = in_tdata[12:5];
  assign i_hdl  = in_tdata[28:13];
  assign i_thr  = in_tdata[32:29];
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    nib = i_tid[4] ? map_hi_r[4*i_tid[3:0] +: 4] : map_lo_r[4*i_tid[3:0] +: 4];
    lvl_ok = ({1'b0, i_tid} < task_count_r) && ({1'b0, i_tid} < 6'(MAX_TASKS)) &&
             (nib != 4'd0) && ({1'b0, nib} <= 5'(LEVELS));
    i_li = LW'(nib - 4'd1);
  end

  // lowest free slot
  always_comb begin
    fs_found = 1'b0;
    fs = '0;
    for (int s = POOL_SLOTS - 1; s >= 0; s--) begin
      if (free_r[s]) begin
        fs_found = 1'b1;
        fs = IW'(s);
      end
    end
  end

  // highest ready level
  always_comb begin
    any_ready = 1'b0;
    top_li = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (ready_r[l]) begin
        any_ready = 1'b1;
        top_li = LW'(l);
      end
    end
    top_lvl = 5'(top_li) + 5'd1;
  end

  // slot memory access
  pmqs_pkg::pmqs_wr_t        mem_wr;
  logic [IW-1:0]             pay_addr, nxt_addr, rd_addr;
  logic [pmqs_pkg::PAY_W-1:0] pay_wdata, rd_pay;
  logic [IW:0]               nxt_wdata, rd_nxt;
  logic                      rem_match;

  assign rem_match = (rd_pay[20:16] == tid_r) && (rd_pay[28:21] == sig_r);

  always_comb begin
    mem_wr    = '0;
    pay_addr  = fs;
    pay_wdata = {i_sig, i_tid, i_hdl};
    nxt_addr  = fs;
    nxt_wdata = NIL;
    rd_addr   = cur_r[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        rd_addr = head_r[top_li];
        if (in_acc && in_tuser == pmqs_pkg::FUNC_POST && lvl_ok && fs_found) begin
          mem_wr.pay_we = 1'b1;
          mem_wr.nxt_we = 1'b1;
        end
      end
      S_POST_LINK: begin
        mem_wr.nxt_we = 1'b1;
        nxt_addr  = link_tail_r;
        nxt_wdata = {1'b0, link_slot_r};
      end
      S_REM_DATA: begin
        nxt_addr  = prev_r[IW-1:0];
        nxt_wdata = rd_nxt;
        mem_wr.nxt_we = rem_match && !prev_r[IW];
      end
      default: begin
      end
    endcase
  end

  pmqs_slot_mem #(.SLOTS(POOL_SLOTS)) u_mem (
    .clk       (clk),
    .wr        (mem_wr),
    .pay_addr  (pay_addr),
    .pay_wdata (pay_wdata),
    .nxt_addr  (nxt_addr),
    .nxt_wdata (nxt_wdata),
    .rd_addr   (rd_addr),
    .rd_pay    (rd_pay),
    .rd_nxt    (rd_nxt)
  );

  // result buffer for remove, drained after the walk so ready_mask is final
  always_ff @(posedge clk) begin
    if (state_r == S_REM_DATA && rem_match) begin
      buf_mem[IW'(cnt_r)] <= rd_pay;
    end
    buf_rd_r <= buf_mem[IW'(k_r)];
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r <= '0;
      map_lo_r     <= '0;
      map_hi_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmqs_pkg::REG_TASK_COUNT: task_count_r <= cfg_wdata[5:0];
        pmqs_pkg::REG_MAP_LOW:    map_lo_r     <= cfg_wdata;
        pmqs_pkg::REG_MAP_HIGH:   map_hi_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tuser  = o_status_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {8'(ready_r), o_cnt_r, o_level_r, o_pay_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= '0;
      free_r  <= '1;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            tid_r      <= i_tid;
            sig_r      <= i_sig;
            li_r       <= i_li;
            o_status_r <= pmqs_pkg::ST_OK;
            o_pay_r    <= '0;
            o_level_r  <= '0;
            o_cnt_r    <= '0;
            o_last_r   <= 1'b1;
            state_r    <= S_OUT;
            unique case (in_tuser)
              pmqs_pkg::FUNC_POST: begin
                if (!lvl_ok) begin
                  o_status_r <= pmqs_pkg::ST_BAD_TASK;
                end else if (!fs_found) begin
                  o_status_r <= pmqs_pkg::ST_FULL;
                end else begin
                  free_r[fs]   <= 1'b0;
                  tail_r[i_li] <= fs;
                  if (ready_r[i_li]) begin
                    link_tail_r <= tail_r[i_li];
                    link_slot_r <= fs;
                    state_r     <= S_POST_LINK;
                  end else begin
                    head_r[i_li]  <= fs;
                    ready_r[i_li] <= 1'b1;
                  end
                end
              end
              pmqs_pkg::FUNC_DISPATCH: begin
                if (!any_ready || top_lvl <= {1'b0, i_thr}) begin
                  o_status_r <= pmqs_pkg::ST_NONE;
                end else begin
                  li_r    <= top_li;
                  cur_r   <= {1'b0, head_r[top_li]};
                  state_r <= S_DISP_DATA;
                end
              end
              pmqs_pkg::FUNC_REMOVE: begin
                if (!lvl_ok) begin
                  o_status_r <= pmqs_pkg::ST_BAD_TASK;
                end else begin
                  cur_r   <= ready_r[i_li] ? {1'b0, head_r[i_li]} : NIL;
                  prev_r  <= NIL;
                  cnt_r   <= '0;
                  steps_r <= '0;
                  state_r <= S_REM_STEP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_POST_LINK: begin
          state_r <= S_OUT;
        end
        S_DISP_DATA: begin
          free_r[cur_r[IW-1:0]] <= 1'b1;
          if (rd_nxt[IW]) begin
            ready_r[li_r] <= 1'b0;
          end else begin
            head_r[li_r] <= rd_nxt[IW-1:0];
          end
          o_pay_r   <= rd_pay;
          o_level_r <= 4'(li_r) + 4'd1;
          state_r   <= S_OUT;
        end
        S_REM_STEP: begin
          if (cur_r[IW] || cnt_r == pmqs_pkg::CNT_W'(pmqs_pkg::MAX_RESULTS) ||
              steps_r == (IW+1)'(POOL_SLOTS)) begin
            if (cnt_r == '0) begin
              state_r <= S_OUT;
            end else begin
              k_r     <= '0;
              state_r <= S_BUF_RD;
            end
          end else begin
            state_r <= S_REM_DATA;
          end
        end
        S_REM_DATA: begin
          steps_r <= steps_r + 1'b1;
          cur_r   <= rd_nxt;
          if (rem_match) begin
            if (prev_r[IW]) begin
              head_r[li_r] <= rd_nxt[IW-1:0];
            end
            if (rd_nxt[IW]) begin
              if (prev_r[IW]) begin
                ready_r[li_r] <= 1'b0;
              end else begin
                tail_r[li_r] <= prev_r[IW-1:0];
              end
            end
            free_r[cur_r[IW-1:0]] <= 1'b1;
            cnt_r <= cnt_r + 1'b1;
          end else begin
            prev_r <= cur_r;
          end
          state_r <= S_REM_STEP;
        end
        S_BUF_RD: begin
          state_r <= S_BUF_DATA;
        end
        S_BUF_DATA: begin
          o_status_r <= pmqs_pkg::ST_OK;
          o_pay_r    <= buf_rd_r;
          o_level_r  <= 4'(li_r) + 4'd1;
          o_cnt_r    <= k_r + 1'b1;
          o_last_r   <= (k_r + 1'b1) == cnt_r;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            if (o_last_r) begin
              state_r <= S_IDLE;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_BUF_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/pmqs_checker.sv =====
// port-level checks for the priority message queue scheduler
// depends on pmqs_pkg and the priority_message_queue_scheduler ports; bound below
module pmqs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one transaction at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready right after transaction");

  // error and empty results are always single
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != pmqs_pkg::ST_OK |-> out_tlast)
    else $error("error result not last");

endmodule

bind priority_message_queue_scheduler pmqs_checker u_pmqs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
